@@ rtl/core/mi3_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int NumElem  = 9;
  localparam int ElemW    = 16;
  localparam int FracBits = 8;
  localparam int CmagW    = 32;               // |adjugate entry| <= 2^31
  localparam int DetW     = 50;               // signed determinant
  localparam int DmagW    = DetW - 1;
  localparam int QBits    = 2 * FracBits + 1; // quotient bits after range check
  localparam int NumW     = DetW;             // |C| << QBits plus |D|
  localparam int CmpW     = NumW + QBits;
  localparam int QDepth   = 8;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = QPtrW + 1;

  // adjugate entry k = e[a]*e[b] - e[c]*e[d], row-major element indexes
  localparam int ADJ_TAB [NumElem][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // one classified matrix, passed from front to back through the queue
  typedef struct packed {
    logic                          singular;
    logic [NumElem-1:0]            neg;
    logic [NumElem-1:0][CmagW-1:0] cmag;
    logic [DmagW-1:0]              dmag;
  } mi3_item_t;

endpackage

@@ rtl/core/mi3_front.sv @@
// Front end: cofactors, determinant and sign classification.
module mi3_front import mi3_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [NumElem-1:0][ElemW-1:0] elems,
  output logic                          out_valid,
  output logic [3:0]                    stage_valid,
  output mi3_item_t                     item
);

  logic signed [ElemW-1:0]   e [NumElem];
  logic signed [2*ElemW-1:0] p0 [NumElem];
  logic signed [2*ElemW-1:0] p1 [NumElem];
  logic signed [2*ElemW:0]   c [NumElem];
  logic signed [ElemW-1:0]   e_d1 [3];
  logic signed [ElemW-1:0]   e_d2 [3];
  logic signed [DmagW-1:0]   t [3];
  logic [NumElem-1:0]        csign;
  logic [NumElem-1:0][CmagW-1:0] cmag;
  logic signed [DetW-1:0]    det;
  logic signed [DetW-1:0]    det_neg;
  logic [3:0]                v;

  for (genvar k = 0; k < NumElem; k++) begin : g_elem
    logic signed [2*ElemW:0] c_neg;
    assign e[k]  = $signed(elems[k]);
    assign c_neg = -c[k];
    always_ff @(posedge clk) begin
      p0[k] <= e[ADJ_TAB[k][0]] * e[ADJ_TAB[k][1]];
      p1[k] <= e[ADJ_TAB[k][2]] * e[ADJ_TAB[k][3]];
      c[k]  <= {p0[k][2*ElemW-1], p0[k]} - {p1[k][2*ElemW-1], p1[k]};
      csign[k] <= c[k][2*ElemW];
      cmag[k]  <= c[k][2*ElemW] ? c_neg[CmagW-1:0] : c[k][CmagW-1:0];
    end
  end

  // det = e0*C0 + e1*C3 + e2*C6 (first-row expansion)
  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk) begin
      e_d1[j] <= e[j];
      e_d2[j] <= e_d1[j];
      t[j]    <= e_d2[j] * c[3 * j];
    end
  end

  assign det     = {t[0][DmagW-1], t[0]} + {t[1][DmagW-1], t[1]} + {t[2][DmagW-1], t[2]};
  assign det_neg = -det;

  always_ff @(posedge clk) begin
    item.singular <= (det == '0);
    item.neg      <= csign ^ {NumElem{det[DetW-1]}};
    item.cmag     <= cmag;
    item.dmag     <= det[DetW-1] ? det_neg[DmagW-1:0] : det[DmagW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], in_valid};
    end
  end

  assign out_valid   = v[3];
  assign stage_valid = v;

endmodule

@@ rtl/core/mi3_queue.sv @@
// Short queue between front and back.
module mi3_queue import mi3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mi3_item_t        din,
  output logic             dvalid,
  output mi3_item_t        dout,
  output logic [QCntW-1:0] count
);

  mi3_item_t        mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic             pop;

  // back end never stalls: drain whenever something is held
  assign pop = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
    if (pop) begin
      dout <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      dvalid <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count  <= count + QCntW'(push) - QCntW'(pop);
      dvalid <= pop;
    end
  end

endmodule

@@ rtl/core/mi3_back.sv @@
// Back end: pipelined restoring divide, rounding and saturation.
module mi3_back import mi3_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  mi3_item_t                     item,
  output logic                          done,
  output logic [NumElem-1:0][ElemW-1:0] inv,
  output logic                          singular,
  output logic                          saturated
);

  localparam logic [QBits-1:0] Lim = QBits'((1 << (ElemW - 1)) - 1);

  logic [QBits:0]                          v;
  logic [QBits:0][NumW-1:0]                dv;
  logic [QBits:0]                          sing;
  logic [QBits:0][NumElem-1:0]             neg;
  logic [QBits:0][NumElem-1:0]             ovf;
  logic [QBits:0][NumElem-1:0][NumW-1:0]   rem;
  logic [QBits:0][NumElem-1:0][QBits-1:0]  quo;

  // entry: numerator = |C|*2^(2F+1) + |D|, divisor = 2|D|
  for (genvar k = 0; k < NumElem; k++) begin : g_in
    logic [NumW-1:0] num;
    assign num = {item.cmag[k], {QBits{1'b0}}} + NumW'(item.dmag);
    always_ff @(posedge clk) begin
      rem[0][k] <= num;
      quo[0][k] <= '0;
      ovf[0][k] <= ({QBits'(0), num} >= ({QBits'(0), item.dmag, 1'b0} << QBits));
    end
  end

  always_ff @(posedge clk) begin
    dv[0]   <= {item.dmag, 1'b0};
    sing[0] <= item.singular;
    neg[0]  <= item.neg;
  end

  // one quotient bit per stage, MSB first
  for (genvar s = 0; s < QBits; s++) begin : g_stage
    for (genvar k = 0; k < NumElem; k++) begin : g_lane
      logic [CmpW-1:0] sub;
      logic            ge;
      assign sub = {QBits'(0), dv[s]} << (QBits - 1 - s);
      assign ge  = ({QBits'(0), rem[s][k]} >= sub);
      always_ff @(posedge clk) begin
        rem[s+1][k] <= ge ? (rem[s][k] - sub[NumW-1:0]) : rem[s][k];
        quo[s+1][k] <= quo[s][k] | (QBits'(ge) << (QBits - 1 - s));
        ovf[s+1][k] <= ovf[s][k];
      end
    end
    always_ff @(posedge clk) begin
      dv[s+1]   <= dv[s];
      sing[s+1] <= sing[s];
      neg[s+1]  <= neg[s];
    end
  end

  logic [NumElem-1:0] sat_lane;

  for (genvar k = 0; k < NumElem; k++) begin : g_out
    logic [QBits-1:0] cap;
    logic [QBits-1:0] mag;
    logic [QBits-1:0] sval;
    assign cap         = Lim + QBits'(neg[QBits][k]);
    assign sat_lane[k] = ovf[QBits][k] || (quo[QBits][k] > cap);
    assign mag         = sat_lane[k] ? cap : quo[QBits][k];
    assign sval        = neg[QBits][k] ? -mag : mag;
    always_ff @(posedge clk) begin
      inv[k] <= sing[QBits] ? '0 : sval[ElemW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    singular  <= sing[QBits];
    saturated <= !sing[QBits] && (sat_lane != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[QBits-1:0], in_valid};
      done <= v[QBits];
    end
  end

endmodule

@@ rtl/core/matrix3_inverse.sv @@
// Top level: 3x3 Q8.8 matrix inverse by adjugate over determinant.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------
//  matrix in | start && !busy       | elem_r0c0 .. elem_r2c2
//  result    | done (one cycle)     | inv_r0c0 .. inv_r2c2, singular, saturated
//
//  One transaction per cycle sustained. The back end divider is fully
//  pipelined, one quotient bit per stage, so the queue never backs up and
//  busy stays low in practice.
//  Synchronous reset clears all valid state. Results cannot be stalled.
module matrix3_inverse import mi3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [15:0] elem_r0c0,
  input  logic signed [15:0] elem_r0c1,
  input  logic signed [15:0] elem_r0c2,
  input  logic signed [15:0] elem_r1c0,
  input  logic signed [15:0] elem_r1c1,
  input  logic signed [15:0] elem_r1c2,
  input  logic signed [15:0] elem_r2c0,
  input  logic signed [15:0] elem_r2c1,
  input  logic signed [15:0] elem_r2c2,
  output logic              done,
  output logic signed [15:0] inv_r0c0,
  output logic signed [15:0] inv_r0c1,
  output logic signed [15:0] inv_r0c2,
  output logic signed [15:0] inv_r1c0,
  output logic signed [15:0] inv_r1c1,
  output logic signed [15:0] inv_r1c2,
  output logic signed [15:0] inv_r2c0,
  output logic signed [15:0] inv_r2c1,
  output logic signed [15:0] inv_r2c2,
  output logic              singular,
  output logic              saturated
);

  logic [NumElem-1:0][ElemW-1:0] elems;
  logic [NumElem-1:0][ElemW-1:0] inv;
  logic                          accept;
  logic                          f_valid;
  logic [3:0]                    f_stages;
  mi3_item_t                     f_item;
  logic                          q_valid;
  mi3_item_t                     q_item;
  logic [QCntW-1:0]              q_count;
  logic [QCntW:0]                inflight;

  assign elems = {elem_r2c2, elem_r2c1, elem_r2c0, elem_r1c2, elem_r1c1,
                  elem_r1c0, elem_r0c2, elem_r0c1, elem_r0c0};

  // credit check: queue entries plus front stages in flight
  assign inflight = (QCntW+1)'(q_count) + (QCntW+1)'($countones(f_stages));
  assign busy     = (inflight >= (QCntW+1)'(QDepth));
  assign accept   = start && !busy;

  mi3_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .elems       (elems),
    .out_valid   (f_valid),
    .stage_valid (f_stages),
    .item        (f_item)
  );

  mi3_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (f_valid),
    .din    (f_item),
    .dvalid (q_valid),
    .dout   (q_item),
    .count  (q_count)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .item      (q_item),
    .done      (done),
    .inv       (inv),
    .singular  (singular),
    .saturated (saturated)
  );

  assign inv_r0c0 = inv[0];
  assign inv_r0c1 = inv[1];
  assign inv_r0c2 = inv[2];
  assign inv_r1c0 = inv[3];
  assign inv_r1c1 = inv[4];
  assign inv_r1c2 = inv[5];
  assign inv_r2c0 = inv[6];
  assign inv_r2c1 = inv[7];
  assign inv_r2c2 = inv[8];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(f_valid && q_count == QCntW'(QDepth)))
    else $error("queue overflow");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (inv == '0 && !saturated))
    else $error("singular result not cleared");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

  a_front_to_queue: assert property (@(posedge clk) disable iff (rst)
    f_valid |=> (q_count != '0))
    else $error("front item lost before queue");

endmodule

@@ tb/sv/matrix3_inverse_checker.sv @@
// Checker for matrix3_inverse: predicts each inverse and compares results.
module matrix3_inverse_checker import mi3_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [ElemW-1:0]  elem [NumElem],
  input  logic                     done,
  input  logic signed [ElemW-1:0]  inv [NumElem],
  input  logic                     singular,
  input  logic                     saturated,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [ElemW-1:0] m [NumElem];
    logic                    sing;
    logic                    sat;
  } inverse_t;

  inverse_t inverse_q[$];
  int       mismatches;

  // exact adjugate over determinant, rounded half away from zero, saturated
  function automatic inverse_t compute_inverse(logic signed [ElemW-1:0] e [NumElem]);
    inverse_t r;
    logic signed [127:0] det, c, adet, num, q;
    logic signed [127:0] x [NumElem];
    logic neg;
    longint lim;
    for (int k = 0; k < NumElem; k++) x[k] = e[k];
    det = x[0]*x[4]*x[8] - x[0]*x[5]*x[7] + x[1]*x[5]*x[6]
        - x[1]*x[3]*x[8] + x[2]*x[3]*x[7] - x[2]*x[4]*x[6];
    r.sat = 1'b0;
    r.sing = (det == 0);
    if (r.sing) begin
      for (int k = 0; k < NumElem; k++) r.m[k] = '0;
      return r;
    end
    adet = det < 0 ? -det : det;
    for (int k = 0; k < NumElem; k++) begin
      c = x[ADJ_TAB[k][0]] * x[ADJ_TAB[k][1]] - x[ADJ_TAB[k][2]] * x[ADJ_TAB[k][3]];
      neg = (c < 0) != (det < 0);
      num = ((c < 0 ? -c : c) <<< (2 * FracBits + 1)) + adet;
      q = num / (adet <<< 1);
      lim = (64'sd1 << (ElemW - 1)) - 1 + (neg ? 1 : 0);
      if (q > lim) begin
        r.sat = 1'b1;
        q = lim;
      end
      r.m[k] = neg ? -q[ElemW-1:0] : q[ElemW-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      inverse_q.delete();
    end else begin
      if (done) begin
        if (inverse_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result with no transaction pending");
        end else begin
          inverse_t exp_r;
          logic bad;
          exp_r = inverse_q.pop_front();
          bad = (exp_r.sing !== singular) || (exp_r.sat !== saturated);
          for (int k = 0; k < NumElem; k++) if (exp_r.m[k] !== inv[k]) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: inverse mismatch at %0t", $realtime);
              for (int k = 0; k < NumElem; k++)
                $display("  elem %0d exp %0d got %0d", k, exp_r.m[k], inv[k]);
              $display("  singular exp %b got %b, saturated exp %b got %b",
                       exp_r.sing, singular, exp_r.sat, saturated);
            end
          end
        end
      end
      if (start && !busy) inverse_q.push_back(compute_inverse(elem));
    end
    pending = inverse_q.size();
  end

  assign fail_count = mismatches;
endmodule

@@ tb/sv/matrix3_inverse_test.sv @@
// Top of the matrix3_inverse testbench: clock, reset, stimulus and verdict.
module matrix3_inverse_test;
  import mi3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst, start, busy, done, singular, saturated;
  logic signed [ElemW-1:0] elem [NumElem];
  logic signed [ElemW-1:0] inv [NumElem];
  int fail_count, pending;

  matrix3_inverse dut (
    .clk, .rst, .start, .busy,
    .elem_r0c0(elem[0]), .elem_r0c1(elem[1]), .elem_r0c2(elem[2]),
    .elem_r1c0(elem[3]), .elem_r1c1(elem[4]), .elem_r1c2(elem[5]),
    .elem_r2c0(elem[6]), .elem_r2c1(elem[7]), .elem_r2c2(elem[8]),
    .done,
    .inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
    .inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
    .inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
    .singular, .saturated
  );

  matrix3_inverse_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // holds start high until the matrix is taken; start stays up for the caller
  // busy only moves at rising edges, so its value at the falling edge decides
  task automatic send_matrix(logic signed [ElemW-1:0] m [NumElem]);
    logic taken;
    elem = m;
    start <= 1'b1;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [ElemW-1:0] rand_elem(int mode);
    case (mode)
      0: return ElemW'($urandom());
      1: return ElemW'($urandom_range(0, 1024) - 512);  // near unity scale
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return ElemW'($urandom_range(0, 8) - 4);
    endcase
  endfunction

  initial begin
    logic signed [ElemW-1:0] m [NumElem];
    int mode, burst;
    start = 1'b0;
    rst = 1'b1;
    for (int k = 0; k < NumElem; k++) elem[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: identity, scaled identity, zero, singular, extremes
    for (int t = 0; t < 12; t++) begin
      for (int k = 0; k < NumElem; k++) m[k] = '0;
      case (t)
        0: begin m[0] = 16'sd256; m[4] = 16'sd256; m[8] = 16'sd256; end
        1: begin m[0] = 16'sd1; m[4] = 16'sd1; m[8] = 16'sd1; end   // saturates
        2: ;                                                          // zero matrix
        3: for (int k = 0; k < NumElem; k++) m[k] = ElemW'(k + 1);    // rank 2
        4: for (int k = 0; k < NumElem; k++) m[k] = 16'sh7fff;
        5: for (int k = 0; k < NumElem; k++) m[k] = 16'sh8000;
        6: begin m[0] = 16'sh8000; m[4] = 16'sh8000; m[8] = 16'sh8000; end
        7: begin m[0] = 16'sh7fff; m[4] = 16'sh8000; m[8] = 16'sh7fff; end
        8: begin m[0] = -16'sd256; m[4] = 16'sd512; m[8] = -16'sd128; m[1] = 16'sd77; end
        9: begin m[2] = 16'sd256; m[4] = 16'sd256; m[6] = 16'sd256; end  // permutation
        10: begin m[0] = -16'sd1; m[4] = 16'sd1; m[8] = -16'sd1; end
        default: for (int k = 0; k < NumElem; k++) m[k] = ElemW'($urandom());
      endcase
      send_matrix(m);
    end
    idle_cycles(3);

    for (int n = 0; n < 2000; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++, n++) begin
        mode = $urandom_range(0, 3);
        for (int k = 0; k < NumElem; k++) m[k] = rand_elem(mode);
        if ($urandom_range(0, 9) == 0) begin
          for (int k = 0; k < 3; k++) m[6 + k] = m[k];        // duplicate row
        end
        send_matrix(m);
      end
      if (n > 1000 && n < 1041) begin
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        idle_cycles($urandom_range(1, 12));
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
